### rtl/stnr_pkg.sv
// ----------------------------------------------------------------------------
// stnr_pkg: shared types and constants of the streaming top-N ranker
// Widths, slot count and the command word passed from front to back.
// ----------------------------------------------------------------------------
package stnr_pkg;

	localparam int TOP_N      = 5;
	localparam int SLOTS      = TOP_N + 1;
	localparam int SLOT_IDX_W = $clog2(SLOTS);
	localparam int KEY_W      = 32;
	localparam int CNT_W      = 31;
	localparam int RANK_W     = 3;
	localparam int TICK_W     = 16;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// work handed from front to back
	typedef struct packed {
		logic             upd;
		logic             emit;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_BUB  = 4'b0100,
		ST_EMIT = 4'b1000
	} back_state_t;

endpackage

### rtl/streaming_top_n_ranker.sv
// ----------------------------------------------------------------------------
// streaming_top_n_ranker: streaming top-N ranking of (key, count) updates
// Front classifies requests, a two-entry queue decouples it from the back,
// which keeps the ordered slot table and emits the ranking.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  request   req_valid / req_stall   req_type, pair_key, pair_count, last_of_tuple
//  ranking   rank_valid / rank_stall rank_pos, ranked_key, ranked_count, last_rank
//  config    cfg_wen                 cfg_wdata (emit_interval)
//
//  Tick words and dropped updates with no emission are handled in the front only.
//  An update passes through the back in steps: dequeue, lookup/write, then one
//  bubble step per place the changed slot moves, plus one to detect the end.
//  An emission streams five ranking words, one per cycle when the output is free.
//  Reset clears the table, queue and output at once; no clearing pass.
//  req_stall rises while the queue is full; rank_stall holds the output word.
// ----------------------------------------------------------------------------
module streaming_top_n_ranker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [stnr_pkg::TICK_W-1:0] cfg_wdata,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        req_type,
	input  logic [stnr_pkg::KEY_W-1:0]  pair_key,
	input  logic [stnr_pkg::CNT_W-1:0]  pair_count,
	input  logic                        last_of_tuple,
	output logic                        rank_valid,
	input  logic                        rank_stall,
	output logic [stnr_pkg::RANK_W-1:0] rank_pos,
	output logic [stnr_pkg::KEY_W-1:0]  ranked_key,
	output logic [stnr_pkg::CNT_W-1:0]  ranked_count,
	output logic                        last_rank
);

	logic           accept;
	logic           push;
	logic           pop;
	logic           empty;
	logic           full;
	stnr_pkg::cmd_t push_cmd;
	stnr_pkg::cmd_t head;

	assign req_stall = full;
	assign accept    = req_valid && !full;

	stnr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.req_type      (req_type),
		.pair_key      (pair_key),
		.pair_count    (pair_count),
		.last_of_tuple (last_of_tuple),
		.push          (push),
		.cmd           (push_cmd)
	);

	stnr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	stnr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.rank_valid   (rank_valid),
		.rank_stall   (rank_stall),
		.rank_pos     (rank_pos),
		.ranked_key   (ranked_key),
		.ranked_count (ranked_count),
		.last_rank    (last_rank)
	);

endmodule

### rtl/stnr_front.sv
// ----------------------------------------------------------------------------
// stnr_front: request intake and classification
// Holds the interval register, tick counter and tuple-stop flag; turns each
// update word that updates or emits into a command for the back end.
// ----------------------------------------------------------------------------
module stnr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [stnr_pkg::TICK_W-1:0] cfg_wdata,
	input  logic                        accept,
	input  logic                        req_type,
	input  logic [stnr_pkg::KEY_W-1:0]  pair_key,
	input  logic [stnr_pkg::CNT_W-1:0]  pair_count,
	input  logic                        last_of_tuple,
	output logic                        push,
	output stnr_pkg::cmd_t              cmd
);

	logic [stnr_pkg::TICK_W-1:0] interval_q;
	logic [stnr_pkg::TICK_W-1:0] ticks_q;
	logic                        stopped_q;
	logic                        is_tick;
	logic                        cnt_zero;
	logic                        emit_now;

	assign is_tick  = (req_type == stnr_pkg::REQ_TICK);
	assign cnt_zero = (pair_count == '0);
	assign emit_now = last_of_tuple && (ticks_q >= interval_q);

	always_comb begin
		cmd.upd  = !stopped_q && !cnt_zero;
		cmd.emit = emit_now;
		cmd.key  = pair_key;
		cmd.cnt  = pair_count;
	end

	assign push = accept && !is_tick && (cmd.upd || cmd.emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= stnr_pkg::TICK_W'(1);
			ticks_q    <= '1;
			stopped_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				interval_q <= cfg_wdata;
			end
			if (accept) begin
				if (is_tick) begin
					if (ticks_q != '1) begin
						ticks_q <= ticks_q + stnr_pkg::TICK_W'(1);
					end
				end else if (last_of_tuple) begin
					stopped_q <= 1'b0;
					if (emit_now) begin
						ticks_q <= '0;
					end
				end else if (cnt_zero) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/stnr_fifo.sv
// ----------------------------------------------------------------------------
// stnr_fifo: command queue between front and back
// Small register queue so each side can stall on its own.
// ----------------------------------------------------------------------------
module stnr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stnr_pkg::cmd_t push_cmd,
	input  logic           pop,
	output stnr_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);

	stnr_pkg::cmd_t                mem_q [stnr_pkg::QDEPTH];
	logic [stnr_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [stnr_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [stnr_pkg::QPTR_W:0]     fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == (stnr_pkg::QPTR_W+1)'(stnr_pkg::QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == stnr_pkg::QPTR_W'(stnr_pkg::QDEPTH-1)) ? '0
				            : wr_ptr_q + stnr_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == stnr_pkg::QPTR_W'(stnr_pkg::QDEPTH-1)) ? '0
				            : rd_ptr_q + stnr_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (stnr_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (stnr_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

### rtl/stnr_back.sv
// ----------------------------------------------------------------------------
// stnr_back: slot table, reorder sequencer and ranking output
// Looks up the key, writes its count, bubbles the changed slot one place
// per cycle into order; on emission, streams the top slots out of a register.
// ----------------------------------------------------------------------------
module stnr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stnr_pkg::cmd_t              head,
	input  logic                        empty,
	output logic                        pop,
	output logic                        rank_valid,
	input  logic                        rank_stall,
	output logic [stnr_pkg::RANK_W-1:0] rank_pos,
	output logic [stnr_pkg::KEY_W-1:0]  ranked_key,
	output logic [stnr_pkg::CNT_W-1:0]  ranked_count,
	output logic                        last_rank
);

	localparam int S = stnr_pkg::SLOTS;

	stnr_pkg::back_state_t           state_q;
	logic [stnr_pkg::KEY_W-1:0]      slot_key_q [S];
	logic [stnr_pkg::CNT_W-1:0]      slot_cnt_q [S];
	logic [stnr_pkg::KEY_W-1:0]      key_q;
	logic [stnr_pkg::CNT_W-1:0]      cnt_q;
	logic                            emit_q;
	logic [S-1:0]                    pos_oh_q;
	logic [stnr_pkg::SLOT_IDX_W-1:0] e_q;

	logic                            out_valid_q;
	logic [stnr_pkg::RANK_W-1:0]     out_pos_q;
	logic [stnr_pkg::KEY_W-1:0]      out_key_q;
	logic [stnr_pkg::CNT_W-1:0]      out_cnt_q;
	logic                            out_last_q;

	logic [S-1:0]   hit_oh;
	logic [S-1:0]   wr_oh;
	logic           found;
	logic [S-2:0]   lt;
	logic [S-2:0]   swap;
	logic [S-1:0]   pos_nxt;
	logic           out_load;
	logic           e_last;

	assign pop = (state_q == stnr_pkg::ST_IDLE) && !empty;

	// first matching slot wins; a miss lands in the spare last slot
	always_comb begin
		found  = 1'b0;
		hit_oh = '0;
		for (int i = 0; i < S; i++) begin
			if (!found && (slot_key_q[i] == key_q)) begin
				hit_oh[i] = 1'b1;
				found     = 1'b1;
			end
		end
		wr_oh = found ? hit_oh : {1'b1, {(S-1){1'b0}}};
	end

	// rest of table stays sorted, so at most one neighbor pair of the moved
	// slot is out of order at a time
	always_comb begin
		pos_nxt = pos_oh_q;
		for (int j = 0; j < S-1; j++) begin
			lt[j]   = slot_cnt_q[j] < slot_cnt_q[j+1];
			swap[j] = (pos_oh_q[j] || pos_oh_q[j+1]) && lt[j];
			if (swap[j]) begin
				pos_nxt[j]   = ~pos_oh_q[j];
				pos_nxt[j+1] = ~pos_oh_q[j+1];
			end
		end
	end

	assign out_load = (state_q == stnr_pkg::ST_EMIT) && (!out_valid_q || !rank_stall);
	assign e_last   = (e_q == stnr_pkg::SLOT_IDX_W'(stnr_pkg::TOP_N-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stnr_pkg::ST_IDLE;
			pos_oh_q <= '0;
			e_q      <= '0;
			emit_q   <= 1'b0;
			key_q    <= '0;
			cnt_q    <= '0;
			for (int i = 0; i < S; i++) begin
				slot_key_q[i] <= '0;
				slot_cnt_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				stnr_pkg::ST_IDLE: begin
					if (pop) begin
						key_q   <= head.key;
						cnt_q   <= head.cnt;
						emit_q  <= head.emit;
						e_q     <= '0;
						state_q <= head.upd ? stnr_pkg::ST_UPD : stnr_pkg::ST_EMIT;
					end
				end
				stnr_pkg::ST_UPD: begin
					for (int i = 0; i < S; i++) begin
						if (wr_oh[i]) begin
							slot_key_q[i] <= key_q;
							slot_cnt_q[i] <= cnt_q;
						end
					end
					pos_oh_q <= wr_oh;
					state_q  <= stnr_pkg::ST_BUB;
				end
				stnr_pkg::ST_BUB: begin
					if (|swap) begin
						for (int j = 0; j < S-1; j++) begin
							if (swap[j]) begin
								slot_key_q[j]   <= slot_key_q[j+1];
								slot_key_q[j+1] <= slot_key_q[j];
								slot_cnt_q[j]   <= slot_cnt_q[j+1];
								slot_cnt_q[j+1] <= slot_cnt_q[j];
							end
						end
						pos_oh_q <= pos_nxt;
					end else begin
						state_q <= emit_q ? stnr_pkg::ST_EMIT : stnr_pkg::ST_IDLE;
					end
				end
				stnr_pkg::ST_EMIT: begin
					if (out_load) begin
						if (e_last) begin
							state_q <= stnr_pkg::ST_IDLE;
						end else begin
							e_q <= e_q + stnr_pkg::SLOT_IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= stnr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && rank_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q  <= stnr_pkg::RANK_W'(e_q);
			out_key_q  <= slot_key_q[e_q];
			out_cnt_q  <= slot_cnt_q[e_q];
			out_last_q <= e_last;
		end
	end

	assign rank_valid   = out_valid_q;
	assign rank_pos     = out_pos_q;
	assign ranked_key   = out_key_q;
	assign ranked_count = out_cnt_q;
	assign last_rank    = out_last_q;

endmodule

### rtl/stnr_checker.sv
// ----------------------------------------------------------------------------
// stnr_checker: port-level checks of the ranking stream
// Rank sequence, last_rank flag, descending counts within an emission, output hold.
// ----------------------------------------------------------------------------
module stnr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rank_valid,
	input logic                        rank_stall,
	input logic [stnr_pkg::RANK_W-1:0] rank_pos,
	input logic [stnr_pkg::KEY_W-1:0]  ranked_key,
	input logic [stnr_pkg::CNT_W-1:0]  ranked_count,
	input logic                        last_rank
);

	logic [stnr_pkg::RANK_W-1:0] exp_pos_q;
	logic [stnr_pkg::CNT_W-1:0]  prev_cnt_q;
	logic                        take;

	assign take = rank_valid && !rank_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_pos_q  <= '0;
			prev_cnt_q <= '0;
		end else if (take) begin
			exp_pos_q  <= last_rank ? '0 : rank_pos + stnr_pkg::RANK_W'(1);
			prev_cnt_q <= ranked_count;
		end
	end

	a_rank_seq: assert property (@(posedge clk) disable iff (!arst_n)
		rank_valid |-> rank_pos == exp_pos_q)
		else $error("ranking word out of sequence");

	a_last_rank: assert property (@(posedge clk) disable iff (!arst_n)
		rank_valid |-> last_rank == (rank_pos == stnr_pkg::RANK_W'(stnr_pkg::TOP_N-1)))
		else $error("last_rank does not match final rank");

	a_descending: assert property (@(posedge clk) disable iff (!arst_n)
		(rank_valid && rank_pos != '0) |-> ranked_count <= prev_cnt_q)
		else $error("ranking counts not descending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rank_valid && rank_stall) |=> rank_valid && $stable(ranked_key)
		&& $stable(ranked_count) && $stable(rank_pos))
		else $error("stalled ranking word changed");

endmodule

bind streaming_top_n_ranker stnr_checker u_stnr_checker (.*);
